@@ src/cebb_pkg.sv @@
// ----------------------------------------------------------------------------
// cebb_pkg
// Shared types, constants and tables for the drawing entity bounding box:
// coordinate and angle widths, entity kinds, box update controls, the
// binary-angle arctangent table and the angle conversion table.
// ----------------------------------------------------------------------------
package cebb_pkg;

  localparam int COORD_W    = 32;
  localparam int CAND_W     = 35;
  localparam int RADIUS_W   = 31;
  localparam int ANGLE_W    = 16;
  localparam int BAM_W      = 32;
  localparam int CORDIC_W   = 32;
  localparam int SCALE_W    = 34;
  localparam int TURN_UNITS = 23040;
  localparam int BAM_DEN    = 45;
  localparam int BAM_FRAC_W = 23;
  localparam int BAM_HALF   = 22;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_CIRCLE = 2'd2;
  localparam logic [1:0] KIND_ARC    = 2'd3;

  typedef struct packed {
    logic seed;
    logic upd_x;
    logic upd_y;
  } box_ctl_t;

  typedef logic [BAM_FRAC_W-1:0] bam_frac_tab_t [BAM_DEN];

  // fraction of a binary angle for each remainder of the reduced angle by 45
  function automatic bam_frac_tab_t bam_frac_table();
    bam_frac_tab_t t;
    for (int i = 0; i < BAM_DEN; i++) begin
      t[i] = BAM_FRAC_W'((longint'(i) * (longint'(1) << BAM_FRAC_W) + longint'(BAM_HALF))
                         / BAM_DEN);
    end
    return t;
  endfunction

  function automatic logic [BAM_W-1:0] atan_bam(input logic [4:0] idx);
    logic [BAM_W-1:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/cebb_box.sv @@
// ----------------------------------------------------------------------------
// cebb_box
// Running box registers. Saturates one x and one y candidate per cycle into
// a holding stage, then widens the box with them in the following cycle.
// ----------------------------------------------------------------------------
module cebb_box (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cebb_pkg::box_ctl_t                     ctl,
  input  logic signed [cebb_pkg::COORD_W-1:0]    seed_x,
  input  logic signed [cebb_pkg::COORD_W-1:0]    seed_y,
  input  logic signed [cebb_pkg::CAND_W-1:0]     cand_x,
  input  logic signed [cebb_pkg::CAND_W-1:0]     cand_y,
  output logic signed [cebb_pkg::COORD_W-1:0]    low_x,
  output logic signed [cebb_pkg::COORD_W-1:0]    high_x,
  output logic signed [cebb_pkg::COORD_W-1:0]    low_y,
  output logic signed [cebb_pkg::COORD_W-1:0]    high_y
);
  import cebb_pkg::*;

  localparam logic signed [CAND_W-1:0] SAT_MAX =
    $signed({{(CAND_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
  localparam logic signed [CAND_W-1:0] SAT_MIN =
    $signed({{(CAND_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic                      pvx;
  logic                      pvy;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [CAND_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    px <= sat(cand_x);
    py <= sat(cand_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvx    <= 1'b0;
      pvy    <= 1'b0;
      low_x  <= '0;
      high_x <= '0;
      low_y  <= '0;
      high_y <= '0;
    end else begin
      pvx <= ctl.upd_x;
      pvy <= ctl.upd_y;
      if (ctl.seed) begin
        low_x  <= seed_x;
        high_x <= seed_x;
        low_y  <= seed_y;
        high_y <= seed_y;
      end else begin
        if (pvx) begin
          if (px < low_x) begin
            low_x <= px;
          end
          if (px > high_x) begin
            high_x <= px;
          end
        end
        if (pvy) begin
          if (py < low_y) begin
            low_y <= py;
          end
          if (py > high_y) begin
            high_y <= py;
          end
        end
      end
    end
  end

endmodule

@@ src/cebb_angle.sv @@
// ----------------------------------------------------------------------------
// cebb_angle
// Three-stage angle converter: reduces a 1/64 degree angle modulo a full
// turn, turns it into a rounded 32-bit binary angle and folds the second and
// third quadrants onto the first and fourth, flagging the fold.
// ----------------------------------------------------------------------------
module cebb_angle (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [cebb_pkg::ANGLE_W-1:0]  angle,
  output logic                                 valid,
  output logic [cebb_pkg::BAM_W-1:0]           bam,
  output logic                                 neg
);
  import cebb_pkg::*;

  localparam int RED_W       = ANGLE_W + 2;
  localparam int M_W         = 15;
  localparam int Q_W         = BAM_W - BAM_FRAC_W;
  localparam int RR_W        = $clog2(BAM_DEN);
  localparam int RECIP       = 23302;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = 30;

  localparam bam_frac_tab_t FRAC_TAB = bam_frac_table();
  localparam logic signed [RED_W-1:0] TURN = RED_W'(TURN_UNITS);

  logic signed [RED_W-1:0] a0;
  logic signed [RED_W-1:0] a1;
  logic signed [RED_W-1:0] a2;
  logic [M_W-1:0]          m1;
  logic [M_W-1:0]          m2;
  logic [Q_W-1:0]          q2;
  logic [PROD_W-1:0]       qprod;
  logic [M_W-1:0]          rem_full;
  logic [RR_W-1:0]         rr;
  logic [BAM_W-1:0]        raw;
  logic                    raw_neg;
  logic                    v1;
  logic                    v2;

  always_comb begin
    a0 = RED_W'(angle);
    a1 = (a0 < 0) ? a0 + TURN : a0;
    if (a1 < 0) begin
      a2 = a1 + TURN;
    end else if (a1 >= TURN) begin
      a2 = a1 - TURN;
    end else begin
      a2 = a1;
    end
    qprod    = PROD_W'(m1) * PROD_W'(RECIP);
    rem_full = m2 - M_W'(q2) * M_W'(BAM_DEN);
    rr       = rem_full[RR_W-1:0];
    raw      = {q2, FRAC_TAB[rr]};
    raw_neg  = raw[BAM_W-1] ^ raw[BAM_W-2];
  end

  always_ff @(posedge clk) begin
    m1  <= a2[M_W-1:0];
    m2  <= m1;
    q2  <= qprod[RECIP_SHIFT +: Q_W];
    bam <= {raw[BAM_W-1] ^ raw_neg, raw[BAM_W-2:0]};
    neg <= raw_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= start;
      v2    <= v1;
      valid <= v2;
    end
  end

endmodule

@@ src/cebb_cordic.sv @@
// ----------------------------------------------------------------------------
// cebb_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with a final
// step that negates the result for folded angles. Gives cos and sin, Q2.30.
// ----------------------------------------------------------------------------
module cebb_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [cebb_pkg::BAM_W-1:0]            bam,
  input  logic                                  neg,
  output logic                                  done,
  output logic signed [cebb_pkg::CORDIC_W-1:0]  cos_val,
  output logic signed [cebb_pkg::CORDIC_W-1:0]  sin_val
);
  import cebb_pkg::*;

  localparam int CNT_W = $clog2(STEPS);

  logic [CNT_W-1:0]           cnt;
  logic                       run;
  logic                       fix;
  logic                       neg_q;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [BAM_W-1:0]    z;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [BAM_W-1:0]    ang;

  always_comb begin
    dx  = y >>> cnt;
    dy  = x >>> cnt;
    ang = $signed(atan_bam(5'(cnt)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fix;
      fix  <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          run <= 1'b0;
          fix <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x     <= CORDIC_GAIN;
      y     <= '0;
      z     <= $signed(bam);
      neg_q <= neg;
    end else if (run) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end
    end else if (fix && neg_q) begin
      x <= -x;
      y <= -y;
    end
  end

  assign cos_val = x;
  assign sin_val = y;

endmodule

@@ src/cad_entity_bounding_box.sv @@
// ----------------------------------------------------------------------------
// cad_entity_bounding_box
// Running axis-aligned box over drawing entities (point, line, circle, arc).
// Arc endpoints come from a shared iterative CORDIC and one multiplier; arc
// sweeps that cross an axis direction add that extreme of the circle.
//
//   channel | signals                          | beat
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_ready, kind .. angs | one entity
//   out     | out_valid, out_ready, box_*      | box after that entity
//
// An arc's result, from accept on, is set by the two CORDIC runs of the shared
// rotator, one per endpoint; points, lines and circles skip the rotator.
// in_ready is high only while the sequencer is idle; the result register is
// loaded once free, so the next entity is taken while a result waits.
// Reset clears the box to all zeros and empties the result register.
// ----------------------------------------------------------------------------
module cad_entity_bounding_box #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            kind,
  input  logic                                  start_new,
  input  logic signed [cebb_pkg::COORD_W-1:0]   first_x,
  input  logic signed [cebb_pkg::COORD_W-1:0]   first_y,
  input  logic signed [cebb_pkg::COORD_W-1:0]   second_x,
  input  logic signed [cebb_pkg::COORD_W-1:0]   second_y,
  input  logic [cebb_pkg::RADIUS_W-1:0]         radius,
  input  logic signed [cebb_pkg::ANGLE_W-1:0]   start_angle,
  input  logic signed [cebb_pkg::ANGLE_W-1:0]   end_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cebb_pkg::COORD_W-1:0]   box_min_x,
  output logic signed [cebb_pkg::COORD_W-1:0]   box_max_x,
  output logic signed [cebb_pkg::COORD_W-1:0]   box_min_y,
  output logic signed [cebb_pkg::COORD_W-1:0]   box_max_y
);
  import cebb_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD_A   = 4'd1;
  localparam logic [3:0] S_ADD_B   = 4'd2;
  localparam logic [3:0] S_GO      = 4'd3;
  localparam logic [3:0] S_WAIT    = 4'd4;
  localparam logic [3:0] S_MUL_C   = 4'd5;
  localparam logic [3:0] S_MUL_S   = 4'd6;
  localparam logic [3:0] S_ADD_END = 4'd7;
  localparam logic [3:0] S_EXT_A   = 4'd8;
  localparam logic [3:0] S_EXT_B   = 4'd9;
  localparam logic [3:0] S_FLUSH   = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  localparam int SW_W      = ANGLE_W + 2;
  localparam int PROD_W    = 2 * CORDIC_W;
  localparam int SCL_SHIFT = 30;
  localparam logic signed [SW_W-1:0]   TURN    = SW_W'(TURN_UNITS);
  localparam logic signed [SW_W-1:0]   QUARTER = SW_W'(TURN_UNITS / 4);
  localparam logic signed [SW_W-1:0]   HALF    = SW_W'(TURN_UNITS / 2);
  localparam logic signed [SW_W-1:0]   THREEQ  = SW_W'(3 * TURN_UNITS / 4);
  localparam logic signed [PROD_W-1:0] RND     = PROD_W'(1) <<< (SCL_SHIFT - 1);

  logic [3:0]                 state;
  logic [3:0]                 state_next;
  logic [1:0]                 kind_q;
  logic signed [COORD_W-1:0]  fx;
  logic signed [COORD_W-1:0]  fy;
  logic signed [COORD_W-1:0]  sx;
  logic signed [COORD_W-1:0]  sy;
  logic [RADIUS_W-1:0]        r_q;
  logic signed [ANGLE_W-1:0]  sa;
  logic signed [ANGLE_W-1:0]  ea;
  logic                       end_sel;
  logic signed [SCALE_W-1:0]  scl_x;
  logic signed [SCALE_W-1:0]  scl_y;

  logic                       accept;
  logic                       out_load;
  logic                       ang_valid;
  logic [BAM_W-1:0]           ang_bam;
  logic                       ang_neg;
  logic                       cordic_done;
  logic signed [CORDIC_W-1:0] cos_val;
  logic signed [CORDIC_W-1:0] sin_val;
  logic signed [CORDIC_W-1:0] mul_a;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SCALE_W-1:0]  scl_val;

  box_ctl_t                   ctl;
  logic signed [COORD_W-1:0]  base_x;
  logic signed [COORD_W-1:0]  base_y;
  logic signed [CAND_W-1:0]   off_x;
  logic signed [CAND_W-1:0]   off_y;
  logic signed [CAND_W-1:0]   r_ext;
  logic signed [CAND_W-1:0]   cand_x;
  logic signed [CAND_W-1:0]   cand_y;
  logic signed [COORD_W-1:0]  low_x;
  logic signed [COORD_W-1:0]  high_x;
  logic signed [COORD_W-1:0]  low_y;
  logic signed [COORD_W-1:0]  high_y;

  logic signed [SW_W-1:0]     sa_w;
  logic signed [SW_W-1:0]     ea_w;
  logic                       cross_0;
  logic                       cross_90;
  logic                       cross_180;
  logic                       cross_270;

  function automatic logic crosses(input logic signed [SW_W-1:0] s,
                                   input logic signed [SW_W-1:0] e,
                                   input logic signed [SW_W-1:0] a);
    return (s < a && e > a) || (s < a + TURN && e > a + TURN);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  cebb_angle u_angle (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GO),
    .angle (end_sel ? ea : sa),
    .valid (ang_valid),
    .bam   (ang_bam),
    .neg   (ang_neg)
  );

  cebb_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (ang_valid),
    .bam     (ang_bam),
    .neg     (ang_neg),
    .done    (cordic_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  always_comb begin
    mul_a   = (state == S_MUL_S) ? sin_val : cos_val;
    prod    = PROD_W'(mul_a) * $signed(PROD_W'(r_q));
    prod_r  = prod + RND;
    scl_val = prod_r[SCL_SHIFT +: SCALE_W];
  end

  always_comb begin
    sa_w      = SW_W'(sa);
    ea_w      = (ea < sa) ? SW_W'(ea) + TURN : SW_W'(ea);
    cross_0   = crosses(sa_w, ea_w, '0);
    cross_90  = crosses(sa_w, ea_w, QUARTER);
    cross_180 = crosses(sa_w, ea_w, HALF);
    cross_270 = crosses(sa_w, ea_w, THREEQ);
  end

  always_comb begin
    r_ext  = $signed(CAND_W'(r_q));
    base_x = fx;
    base_y = fy;
    off_x  = '0;
    off_y  = '0;
    ctl    = '0;
    unique case (state)
      S_ADD_A: begin
        ctl.upd_x = 1'b1;
        ctl.upd_y = 1'b1;
        if (kind_q == KIND_CIRCLE) begin
          off_x = r_ext;
          off_y = r_ext;
        end
      end
      S_ADD_B: begin
        ctl.upd_x = 1'b1;
        ctl.upd_y = 1'b1;
        if (kind_q == KIND_LINE) begin
          base_x = sx;
          base_y = sy;
        end else begin
          off_x = -r_ext;
          off_y = -r_ext;
        end
      end
      S_ADD_END: begin
        ctl.upd_x = 1'b1;
        ctl.upd_y = 1'b1;
        off_x     = CAND_W'(scl_x);
        off_y     = CAND_W'(scl_y);
      end
      S_EXT_A: begin
        ctl.upd_x = cross_0;
        ctl.upd_y = cross_90;
        off_x     = r_ext;
        off_y     = r_ext;
      end
      S_EXT_B: begin
        ctl.upd_x = cross_180;
        ctl.upd_y = cross_270;
        off_x     = -r_ext;
        off_y     = -r_ext;
      end
      default: begin
      end
    endcase
    ctl.seed = accept && start_new;
    cand_x   = CAND_W'(base_x) + off_x;
    cand_y   = CAND_W'(base_y) + off_y;
  end

  cebb_box u_box (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .seed_x (first_x),
    .seed_y (first_y),
    .cand_x (cand_x),
    .cand_y (cand_y),
    .low_x  (low_x),
    .high_x (high_x),
    .low_y  (low_y),
    .high_y (high_y)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_ARC) ? S_GO : S_ADD_A;
        end
      end
      S_ADD_A:   state_next = (kind_q == KIND_POINT) ? S_FLUSH : S_ADD_B;
      S_ADD_B:   state_next = S_FLUSH;
      S_GO:      state_next = S_WAIT;
      S_WAIT: begin
        if (cordic_done) begin
          state_next = S_MUL_C;
        end
      end
      S_MUL_C:   state_next = S_MUL_S;
      S_MUL_S:   state_next = S_ADD_END;
      S_ADD_END: state_next = end_sel ? S_EXT_A : S_GO;
      S_EXT_A:   state_next = S_EXT_B;
      S_EXT_B:   state_next = S_FLUSH;
      S_FLUSH:   state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      end_sel   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        end_sel <= 1'b0;
      end else if (state == S_ADD_END) begin
        end_sel <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      fx     <= first_x;
      fy     <= first_y;
      sx     <= second_x;
      sy     <= second_y;
      r_q    <= radius;
      sa     <= start_angle;
      ea     <= end_angle;
    end
    if (state == S_MUL_C) begin
      scl_x <= scl_val;
    end
    if (state == S_MUL_S) begin
      scl_y <= scl_val;
    end
    if (out_load) begin
      box_min_x <= low_x;
      box_max_x <= high_x;
      box_min_y <= low_y;
      box_max_y <= high_y;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == S_WAIT)
    else $error("rotator finished outside the wait step");

  assert property (@(posedge clk) disable iff (rst)
    (low_x <= high_x) && (low_y <= high_y))
    else $error("box corners out of order");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result beat raised outside the output step");

endmodule
